/* rtl/core/pwmdiv_pkg.sv */
// shared widths, limits and status codes of the pwm divider solver
package pwmdiv_pkg;

    localparam int CLK_W       = 28;
    localparam int FREQ_W      = 35;
    localparam int NUM_W       = CLK_W + 12;
    localparam int DIV_W       = 12;
    localparam int TOP_W       = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam int COUNTER_TOP_MAX_DEF = 65534;

    localparam logic [CLK_W-1:0] CLK_RESET   = 28'd125000000;
    localparam logic [DIV_W:0]   DIV_LOWEST  = 13'h010;
    localparam logic [DIV_W:0]   DIV_HIGHEST = 13'h0FFF;
    localparam logic [DIV_W:0]   DIV_OVER    = 13'h1000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LOW  = 2'd1,
        ST_HIGH = 2'd2
    } t_status;

endpackage

/* rtl/core/pwmdiv_sdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle
module pwmdiv_sdiv #(
    parameter int NW = 40,
    parameter int DW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DW:0]      trial;
    logic             ge;
    logic [DW:0]      diff;

    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    // dividend shifts out at the top while quotient bits fill in at the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

/* rtl/core/pwm_divider_top_solver.sv */
// pwm divider solver: request frequency in, 8.4 clock divider and wrap value out
//
// A request runs from its accepting cycle through three passes of a 40-step
// bit-serial divider (40 shifts and a done strobe each: clock*4096/f, then that by
// the span and span+1 in parallel, then by the chosen divider) and then loads the
// output register, where the result word becomes valid. A zero frequency goes
// straight to the output register, and a request already known to be too low after
// the second pass skips the third. The next request is taken once the result has
// moved into the output register, even while that word still waits on the output;
// a finished result that finds the output register still full waits in S_DONE for
// as long as the back-pressure lasts.
// Result word: status (0 ok, 1 too low, 2 too high), divider and wrap_top are 0
// unless status is ok. The clock register may be written only while idle.
module pwm_divider_top_solver #(
    parameter int COUNTER_TOP_MAX = pwmdiv_pkg::COUNTER_TOP_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // clock register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pwmdiv_pkg::CLK_W-1:0]       i_cfg_data,
    // requests
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [34:0] requested_freq_q8
    input  logic [pwmdiv_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // results
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [1:0] status, [13:2] divider, [29:14] wrap_top
    output logic [pwmdiv_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    import pwmdiv_pkg::*;

    localparam int SPAN_B_W = $clog2(COUNTER_TOP_MAX + 3);
    localparam logic [FREQ_W-1:0]   SPAN_A = FREQ_W'(COUNTER_TOP_MAX + 1);
    localparam logic [SPAN_B_W-1:0] SPAN_B = SPAN_B_W'(COUNTER_TOP_MAX + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SPAN,
        S_PER,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CLK_W-1:0]   r_clk_hz;
    logic [NUM_W-1:0]   r_q0;
    logic [DIV_W-1:0]   r_div;
    t_status            r_res_status;
    logic [DIV_W-1:0]   r_res_div;
    logic [TOP_W-1:0]   r_res_top;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [DIV_W-1:0]   r_out_div;
    logic [TOP_W-1:0]   r_out_top;

    logic [FREQ_W-1:0]   in_freq;
    logic                in_acc;
    logic                a_start;
    logic [NUM_W-1:0]    a_dividend;
    logic [FREQ_W-1:0]   a_divisor;
    logic                a_done;
    logic [NUM_W-1:0]    a_quo;
    logic                b_start;
    logic                b_done;
    logic [NUM_W-1:0]    b_quo;
    logic                q1_big;
    logic [DIV_W:0]      div_start;
    logic [DIV_W:0]      div_min;
    logic [DIV_W:0]      div_sel;
    logic                out_free;

    assign in_freq         = i_s_axis_tdata[FREQ_W-1:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // divider after the span pass: max(clamped start, first divider that fits)
    always_comb begin
        q1_big    = |a_quo[NUM_W-1:DIV_W];
        div_start = {1'b0, a_quo[DIV_W-1:0]};
        if (div_start < DIV_LOWEST) begin
            div_start = DIV_LOWEST;
        end
        if (b_quo >= NUM_W'(DIV_HIGHEST)) begin
            div_min = DIV_OVER;
        end else begin
            div_min = b_quo[DIV_W:0] + 1'b1;
        end
        div_sel = (div_start > div_min) ? div_start : div_min;
    end

    always_comb begin
        a_start    = 1'b0;
        b_start    = 1'b0;
        a_dividend = r_q0;
        a_divisor  = SPAN_A;
        case (r_state)
            S_IDLE: begin
                if (in_acc && in_freq != '0) begin
                    a_start    = 1'b1;
                    a_dividend = {r_clk_hz, 12'd0};
                    a_divisor  = in_freq;
                end
            end
            S_BASE: begin
                if (a_done) begin
                    a_start    = 1'b1;
                    b_start    = 1'b1;
                    a_dividend = a_quo;
                end
            end
            S_SPAN: begin
                if (a_done && b_done && !q1_big && div_sel != DIV_OVER) begin
                    a_start   = 1'b1;
                    a_divisor = FREQ_W'(div_sel);
                end
            end
            default: begin
            end
        endcase
    end

    pwmdiv_sdiv #(.NW(NUM_W), .DW(FREQ_W)) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (a_start),
        .i_dividend (a_dividend),
        .i_divisor  (a_divisor),
        .o_done     (a_done),
        .o_quotient (a_quo)
    );

    pwmdiv_sdiv #(.NW(NUM_W), .DW(SPAN_B_W)) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (b_start),
        .i_dividend (a_quo),
        .i_divisor  (SPAN_B),
        .o_done     (b_done),
        .o_quotient (b_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clk_hz    <= CLK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_clk_hz <= i_cfg_data;
            end
            // a word leaving while the next one loads is handled in S_DONE
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_freq == '0) begin
                            r_res_status <= ST_LOW;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    if (a_done) begin
                        r_q0    <= a_quo;
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    if (a_done && b_done) begin
                        if (q1_big || div_sel == DIV_OVER) begin
                            r_res_status <= ST_LOW;
                            r_state      <= S_DONE;
                        end else begin
                            r_div   <= div_sel[DIV_W-1:0];
                            r_state <= S_PER;
                        end
                    end
                end
                S_PER: begin
                    if (a_done) begin
                        // period is at most the span here, so 16 bits hold it
                        if (a_quo <= NUM_W'(1)) begin
                            r_res_status <= ST_HIGH;
                        end else begin
                            r_res_status <= ST_OK;
                            r_res_div    <= r_div;
                            r_res_top    <= a_quo[TOP_W-1:0] - 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_div    <= (r_res_status == ST_OK) ? r_res_div : '0;
                        r_out_top    <= (r_res_status == ST_OK) ? r_res_top : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_top, r_out_div, r_out_status};

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_div == '0 && r_out_top == '0)
        else $error("error result carries a nonzero divider or wrap");

    a_ok_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_OK |-> {1'b0, r_out_div} >= DIV_LOWEST)
        else $error("ok result with divider below one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("request taken but solver still idle");

    a_span_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPAN && a_done |-> b_done)
        else $error("span dividers out of step");

endmodule

/* tb/sv/pwm_solver_checker.sv */
// result checker for the pwm divider solver: tracks the clock register, predicts and compares
module pwm_solver_checker #(
    parameter int COUNTER_TOP_MAX = pwmdiv_pkg::COUNTER_TOP_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [pwmdiv_pkg::CLK_W-1:0]       i_cfg_data,
    input  logic                               i_req_valid,
    input  logic                               i_req_ready,
    // [34:0] requested_freq_q8
    input  logic [pwmdiv_pkg::IN_TDATA_W-1:0]  i_req_data,
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    // [1:0] status, [13:2] divider, [29:14] wrap_top
    input  logic [pwmdiv_pkg::OUT_TDATA_W-1:0] i_res_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import pwmdiv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status          status;
        logic [DIV_W-1:0] divider;
        logic [TOP_W-1:0] wrap_top;
    } t_solution;

    logic [CLK_W-1:0] clock_hz = CLK_RESET;
    t_solution        pending_solutions[$];
    int               mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // exact integer search for the 8.4 divider and the wrap value
    function automatic t_solution solve_divider(input logic [CLK_W-1:0] clk_hz,
                                                input logic [FREQ_W-1:0] freq_q8);
        logic [63:0] num;
        logic [63:0] span;
        logic [63:0] freq;
        logic [63:0] div;
        logic [63:0] period;
        t_solution   sol;
        sol = '{status: ST_OK, divider: '0, wrap_top: '0};
        span = 64'(COUNTER_TOP_MAX) + 64'd1;
        num = 64'(clk_hz) << 12;
        freq = 64'(freq_q8);
        if (freq == 0) begin
            sol.status = ST_LOW;
            return sol;
        end
        div = num / (freq * span);
        if (div < 64'(DIV_LOWEST))
            div = 64'(DIV_LOWEST);
        forever begin
            period = num / (div * freq);
            if (!(period > span && div <= 64'(DIV_HIGHEST)))
                break;
            div = div + 64'd1;
        end
        if (period <= 64'd1) begin
            sol.status = ST_HIGH;
        end else if (div > 64'(DIV_HIGHEST)) begin
            sol.status = ST_LOW;
        end else begin
            sol.divider  = div[DIV_W-1:0];
            sol.wrap_top = TOP_W'(period - 64'd1);
        end
        return sol;
    endfunction

    always @(posedge i_clk) begin
        t_solution        want;
        t_status          got_status;
        logic [DIV_W-1:0] got_div;
        logic [TOP_W-1:0] got_top;
        if (!i_rst_n) begin
            clock_hz = CLK_RESET;
            pending_solutions.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got_status = t_status'(i_res_data[1:0]);
                got_div    = i_res_data[13:2];
                got_top    = i_res_data[29:14];
                if (pending_solutions.size() == 0) begin
                    $error("unexpected result word: status %0d divider 0x%03h wrap_top %0d",
                           got_status, got_div, got_top);
                    mismatch_count++;
                end else begin
                    want = pending_solutions.pop_front();
                    if (got_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got_status);
                        mismatch_count++;
                    end
                    if (got_div !== want.divider) begin
                        $error("divider: expected 0x%03h, actual 0x%03h",
                               want.divider, got_div);
                        mismatch_count++;
                    end
                    if (got_top !== want.wrap_top) begin
                        $error("wrap_top: expected %0d, actual %0d", want.wrap_top, got_top);
                        mismatch_count++;
                    end
                end
            end
            // a request taken on the same edge as a write still sees the old clock
            if (i_req_valid && i_req_ready)
                pending_solutions.push_back(solve_divider(clock_hz, i_req_data[FREQ_W-1:0]));
            if (i_cfg_valid && i_cfg_ready)
                clock_hz = i_cfg_data;
        end
        o_pending <= pending_solutions.size();
    end

endmodule

/* tb/sv/tb_pwm_divider_top_solver.sv */
// testbench top for the pwm divider solver: clock, reset, stimulus and verdict
module tb_pwm_divider_top_solver;
    import pwmdiv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int          PHASE_ITEMS  = 250;
    localparam int          DRAIN_CYCLES = 300;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CLK_W-1:0]       cfg_data = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] res_data;

    int                     fail_count;
    int                     pending;
    logic                   quiet = 1'b0;
    logic                   hold_req = 1'b0;
    logic                   hold_taken = 1'b0;
    int unsigned            hold_left = 0;
    int unsigned            cycle_count = 0;

    always #2 i_clk = ~i_clk;

    pwm_divider_top_solver dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    pwm_solver_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!rst_n) begin
            res_ready  <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            res_ready  <= 1'b0;
        end else begin
            res_ready <= quiet || ($urandom_range(0, 99) >= 6);
        end
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("pwm_divider_top_solver regression: fail");
        $finish;
    end

    task automatic push_request(input logic [FREQ_W-1:0] freq_q8);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= IN_TDATA_W'(freq_q8);
        do @(posedge i_clk); while (!req_ready);
    endtask

    // only while idle: stop requests and let every result drain first
    task automatic write_clock(input logic [CLK_W-1:0] value);
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly log-spread frequencies, some near the too-high and too-low borders
    function automatic logic [FREQ_W-1:0] random_freq(input logic [CLK_W-1:0] clk_hz);
        logic [63:0] wide;
        logic [63:0] anchor;
        logic [63:0] jitter;
        int          sel;
        int          nbits;
        wide = {$urandom, $urandom};
        sel  = $urandom_range(0, 9);
        if (sel < 2) begin
            anchor = (sel == 0) ? 64'(clk_hz) * 64'd128 : 64'(clk_hz) / 64'd65535;
            jitter = 64'($urandom_range(0, 128));
            return (anchor + jitter < 64'd64) ? '0 : FREQ_W'(anchor + jitter - 64'd64);
        end
        if (sel == 2)
            return wide[FREQ_W-1:0];
        nbits = $urandom_range(1, FREQ_W);
        return FREQ_W'(wide & ((64'd1 << nbits) - 64'd1));
    endfunction

    initial begin
        logic [FREQ_W-1:0] corner_freqs[$] = '{
            35'd0, 35'd1, 35'd2, 35'h7FFFFFFFF, 35'h400000000, 35'd256,
            35'd1906, 35'd1907, 35'd1908, 35'd1909, 35'd15999999999,
            35'd16000000000, 35'd16000000001, 35'd8000000000, 35'd256000,
            35'd12800000, 35'd256000000, 35'd65535
        };
        logic [CLK_W-1:0]  phase_clocks[8];
        phase_clocks[0] = 28'hFFFFFFF;
        phase_clocks[1] = 28'd1;
        phase_clocks[2] = CLK_RESET;
        phase_clocks[3] = 28'd48000000;
        phase_clocks[4] = CLK_W'($urandom_range(1, 28'hFFFFFFF));
        phase_clocks[5] = 28'd133000000;
        phase_clocks[6] = CLK_W'($urandom_range(1, 100000));
        phase_clocks[7] = CLK_W'($urandom_range(1, 28'hFFFFFFF));

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset clock value first, then a zero clock
        foreach (corner_freqs[i])
            push_request(corner_freqs[i]);
        write_clock('0);
        push_request(35'd0);
        push_request(35'd256);
        push_request(35'h7FFFFFFFF);

        foreach (phase_clocks[p]) begin
            write_clock(phase_clocks[p]);
            hold_req <= (p == 2);
            quiet    <= (p == 4);
            repeat (PHASE_ITEMS)
                push_request(random_freq(phase_clocks[p]));
        end

        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("pwm_divider_top_solver regression: pass");
        else
            $display("pwm_divider_top_solver regression: fail");
        $finish;
    end

endmodule
